// ===== sv/ami_pkg.sv =====
// ============================================================================
// ami_pkg
// Shared types and constants of the affine matrix inverse block.
// ============================================================================
package ami_pkg;

   // element width and fixed-point scale
   localparam int DW        = 32;
   localparam int FRAC_BITS = 24;

   // configuration
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 3;
   localparam int THR_W  = 25;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);
   localparam logic [CSR_AW-3:0] REG_DET_THRESHOLD = '0;

   // internal widths
   localparam int PROD_W   = 2 * DW;
   localparam int DIFF_W   = PROD_W + 1;
   localparam int ADJ_W    = DIFF_W - FRAC_BITS;
   localparam int ADJ_HI_W = ADJ_W - FRAC_BITS;
   localparam int PL_W     = DW + FRAC_BITS + 1;
   localparam int PH_W     = DW + ADJ_HI_W;
   localparam int DSUM_W   = DW + ADJ_W + 2;
   localparam int DET_W    = DSUM_W - FRAC_BITS;
   localparam int NUM_W    = ADJ_W + FRAC_BITS + 2;
   localparam int DEN_W    = DET_W + 1;
   localparam int QB       = DW;
   localparam int DIV_LAT  = QB + 3;
   localparam int ACC_W    = PROD_W + 2;
   localparam int TR_W     = ACC_W + 1 - FRAC_BITS;

   localparam logic [1:0] ROW_FIRST = 2'd0;
   localparam logic [1:0] ROW_LAST  = 2'd3;

   typedef struct packed {
      logic signed [DW-1:0] m00;
      logic signed [DW-1:0] m01;
      logic signed [DW-1:0] m02;
      logic signed [DW-1:0] m10;
      logic signed [DW-1:0] m11;
      logic signed [DW-1:0] m12;
      logic signed [DW-1:0] m20;
      logic signed [DW-1:0] m21;
      logic signed [DW-1:0] m22;
      logic signed [DW-1:0] tx;
      logic signed [DW-1:0] ty;
      logic signed [DW-1:0] tz;
   } ami_req_type;

   typedef struct packed {
      logic [1:0]           row_index;
      logic signed [DW-1:0] col0;
      logic signed [DW-1:0] col1;
      logic signed [DW-1:0] col2;
      logic                 singular;
      logic                 saturated;
      logic                 last;
   } ami_rsp_type;

   // control that travels beside the divider lanes
   typedef struct packed {
      logic                 valid;
      logic [1:0]           row;
      logic                 singular;
      logic signed [DW-1:0] t;
   } ami_side_type;

endpackage

// ===== sv/ami_div.sv =====
// ============================================================================
// ami_div
// Pipelined rounding divider lane, one quotient bit per stage, saturating.
// ============================================================================
module ami_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [ami_pkg::NUM_W-1:0]    in_num,
   input  logic [ami_pkg::DEN_W-1:0]    in_den,
   input  logic                         in_neg,
   output logic signed [ami_pkg::DW-1:0] quo,
   output logic                         clip
);
   import ami_pkg::*;

   logic [NUM_W-1:0] pre_num_ff;
   logic [DEN_W-1:0] pre_den_ff;
   logic             pre_neg_ff;

   logic [DEN_W-1:0] rem_ff [QB+1];
   logic [QB-1:0]    low_ff [QB+1];
   logic [QB-1:0]    q_ff   [QB+1];
   logic [DEN_W-1:0] den_ff [QB+1];
   logic             neg_ff [QB+1];
   logic             ovf_ff [QB+1];

   logic             ovf_in;
   logic             clip_in;

   // quotient would not fit the 32-bit magnitude
   assign ovf_in = ((DEN_W+QB)'(pre_num_ff)) >= {pre_den_ff, {QB{1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         pre_num_ff <= in_num;
         pre_den_ff <= in_den;
         pre_neg_ff <= in_neg;
         rem_ff[0]  <= DEN_W'(pre_num_ff[NUM_W-1:QB]);
         low_ff[0]  <= pre_num_ff[QB-1:0];
         q_ff[0]    <= '0;
         den_ff[0]  <= pre_den_ff;
         neg_ff[0]  <= pre_neg_ff;
         ovf_ff[0]  <= ovf_in;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;
      assign trial = {rem_ff[k-1], low_ff[k-1][QB-k]};
      assign ge    = trial >= {1'b0, den_ff[k-1]};
      assign diff  = trial - {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_ff[k] <= low_ff[k-1];
            q_ff[k]   <= q_ff[k-1] | (QB'(ge) << (QB-k));
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   // positive side clips at 2^31, negative side beyond 2^31
   assign clip_in = ovf_ff[QB]
                  || (!neg_ff[QB] && q_ff[QB][QB-1])
                  || (neg_ff[QB] && q_ff[QB][QB-1] && (|q_ff[QB][QB-2:0]));

   always_ff @(posedge clock) begin
      if (en) begin
         clip <= clip_in;
         if (clip_in) begin
            quo <= neg_ff[QB] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
         end else begin
            quo <= neg_ff[QB] ? DW'(-q_ff[QB]) : DW'(q_ff[QB]);
         end
      end
   end

endmodule

// ===== sv/affine_matrix_inverse.sv =====
// ============================================================================
// affine_matrix_inverse
// Inverse of a 4x4 affine matrix in signed Q8.24, four result rows per request.
// ============================================================================
// A request carries the 3x3 linear part and the translation row. The block
// forms the adjugate and determinant, divides the adjugate by the determinant
// with round-to-nearest (ties away from zero) and builds the translation row
// as -(t * inv). If |det| is zero or below det_threshold it returns the
// identity with singular set. Results come out as rows 0..3, last on row 3.
// A new request is taken only while the row sequencer is free; it feeds the
// three divider lanes one inverse row per cycle while rsp is not stalled. The
// edge that takes a request loads the first of 44 register stages (5 front
// stages, sequencer, 35-stage divider lanes, product, accumulate and output
// register). The whole pipe holds on rsp back-pressure; req_ready follows
// rsp_ready combinationally and also waits for the row sequencer.
module affine_matrix_inverse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  ami_pkg::ami_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ami_pkg::ami_rsp_type         rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ami_pkg::CSR_AW-1:0]   paddr,
   input  logic [ami_pkg::CSR_DW-1:0]   pwdata,
   output logic [ami_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);
   import ami_pkg::*;

   // ------------------------------------------------------------------ csr
   logic [THR_W-1:0] thr_ff;
   logic             reg_hit;

   assign reg_hit = (paddr[CSR_AW-1:2] == REG_DET_THRESHOLD);
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? CSR_DW'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         thr_ff <= pwdata[THR_W-1:0];
      end
   end

   // ------------------------------------------------------------ enables
   logic       back_en;
   logic       front_en;
   logic       exp_free;
   logic       rsp_valid_ff;
   logic       exp_valid_ff;
   logic [1:0] exp_row_ff;

   assign back_en   = !rsp_valid_ff || rsp_ready;
   assign exp_free  = !exp_valid_ff || (exp_row_ff == ROW_LAST);
   assign front_en  = back_en && exp_free;
   assign req_ready = front_en;

   // ------------------------------------------- stage 1: minor products
   logic signed [DW-1:0]     m_in [3][3];
   logic signed [DW-1:0]     t_in [3];
   logic signed [PROD_W-1:0] pa_in [3][3];
   logic signed [PROD_W-1:0] pb_in [3][3];

   logic                     s1_valid_ff;
   logic signed [DW-1:0]     s1_m0_ff [3];
   logic signed [DW-1:0]     s1_t_ff  [3];
   logic signed [PROD_W-1:0] s1_pa_ff [3][3];
   logic signed [PROD_W-1:0] s1_pb_ff [3][3];

   assign m_in[0][0] = req_data.m00;
   assign m_in[0][1] = req_data.m01;
   assign m_in[0][2] = req_data.m02;
   assign m_in[1][0] = req_data.m10;
   assign m_in[1][1] = req_data.m11;
   assign m_in[1][2] = req_data.m12;
   assign m_in[2][0] = req_data.m20;
   assign m_in[2][1] = req_data.m21;
   assign m_in[2][2] = req_data.m22;
   assign t_in[0]    = req_data.tx;
   assign t_in[1]    = req_data.ty;
   assign t_in[2]    = req_data.tz;

   // adjugate as pairs of 2x2 cross products
   always_comb begin
      pa_in[0][0] = PROD_W'(m_in[1][1]) * PROD_W'(m_in[2][2]);
      pb_in[0][0] = PROD_W'(m_in[1][2]) * PROD_W'(m_in[2][1]);
      pa_in[0][1] = PROD_W'(m_in[0][2]) * PROD_W'(m_in[2][1]);
      pb_in[0][1] = PROD_W'(m_in[0][1]) * PROD_W'(m_in[2][2]);
      pa_in[0][2] = PROD_W'(m_in[0][1]) * PROD_W'(m_in[1][2]);
      pb_in[0][2] = PROD_W'(m_in[0][2]) * PROD_W'(m_in[1][1]);
      pa_in[1][0] = PROD_W'(m_in[1][2]) * PROD_W'(m_in[2][0]);
      pb_in[1][0] = PROD_W'(m_in[1][0]) * PROD_W'(m_in[2][2]);
      pa_in[1][1] = PROD_W'(m_in[0][0]) * PROD_W'(m_in[2][2]);
      pb_in[1][1] = PROD_W'(m_in[0][2]) * PROD_W'(m_in[2][0]);
      pa_in[1][2] = PROD_W'(m_in[0][2]) * PROD_W'(m_in[1][0]);
      pb_in[1][2] = PROD_W'(m_in[0][0]) * PROD_W'(m_in[1][2]);
      pa_in[2][0] = PROD_W'(m_in[1][0]) * PROD_W'(m_in[2][1]);
      pb_in[2][0] = PROD_W'(m_in[1][1]) * PROD_W'(m_in[2][0]);
      pa_in[2][1] = PROD_W'(m_in[0][1]) * PROD_W'(m_in[2][0]);
      pb_in[2][1] = PROD_W'(m_in[0][0]) * PROD_W'(m_in[2][1]);
      pa_in[2][2] = PROD_W'(m_in[0][0]) * PROD_W'(m_in[1][1]);
      pb_in[2][2] = PROD_W'(m_in[0][1]) * PROD_W'(m_in[1][0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (front_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s1_m0_ff <= m_in[0];
         s1_t_ff  <= t_in;
         s1_pa_ff <= pa_in;
         s1_pb_ff <= pb_in;
      end
   end

   // ------------------------------------------- stage 2: rounded adjugate
   logic signed [ADJ_W-1:0] adj_in [3][3];
   logic                    s2_valid_ff;
   logic signed [DW-1:0]    s2_m0_ff  [3];
   logic signed [DW-1:0]    s2_t_ff   [3];
   logic signed [ADJ_W-1:0] s2_adj_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            logic signed [DIFF_W-1:0] d;
            d = DIFF_W'(s1_pa_ff[i][j]) - DIFF_W'(s1_pb_ff[i][j])
              + DIFF_W'(1 << (FRAC_BITS - 1));
            adj_in[i][j] = d[DIFF_W-1:FRAC_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (front_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s2_m0_ff  <= s1_m0_ff;
         s2_t_ff   <= s1_t_ff;
         s2_adj_ff <= adj_in;
      end
   end

   // ------------------------------------ stage 3: determinant partials
   // adjugate column 0 split into a signed high part and unsigned low part
   logic signed [PL_W-1:0]  pl_in [3];
   logic signed [PH_W-1:0]  ph_in [3];
   logic                    s3_valid_ff;
   logic signed [DW-1:0]    s3_t_ff   [3];
   logic signed [ADJ_W-1:0] s3_adj_ff [3][3];
   logic signed [PL_W-1:0]  s3_pl_ff  [3];
   logic signed [PH_W-1:0]  s3_ph_ff  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pl_in[i] = PL_W'(s2_m0_ff[i])
                  * PL_W'($signed({1'b0, s2_adj_ff[i][0][FRAC_BITS-1:0]}));
         ph_in[i] = PH_W'(s2_m0_ff[i])
                  * PH_W'($signed(s2_adj_ff[i][0][ADJ_W-1:FRAC_BITS]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (front_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s3_t_ff   <= s2_t_ff;
         s3_adj_ff <= s2_adj_ff;
         s3_pl_ff  <= pl_in;
         s3_ph_ff  <= ph_in;
      end
   end

   // ------------------------------------------ stage 4: determinant sum
   logic signed [DSUM_W-1:0] dsum_in;
   logic                     s4_valid_ff;
   logic signed [DW-1:0]     s4_t_ff    [3];
   logic signed [ADJ_W-1:0]  s4_adj_ff  [3][3];
   logic signed [DSUM_W-1:0] s4_dsum_ff;

   always_comb begin
      dsum_in = '0;
      for (int i = 0; i < 3; i++) begin
         dsum_in = dsum_in + (DSUM_W'(s3_ph_ff[i]) <<< FRAC_BITS) + DSUM_W'(s3_pl_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (front_en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s4_t_ff    <= s3_t_ff;
         s4_adj_ff  <= s3_adj_ff;
         s4_dsum_ff <= dsum_in;
      end
   end

   // --------------------------- stage 5: rounded det, magnitude, singular
   logic signed [DSUM_W-1:0] dround;
   logic signed [DET_W-1:0]  det;
   logic [DET_W-1:0]         mag_in;
   logic                     sing_in;
   logic                     s5_valid_ff;
   logic signed [DW-1:0]     s5_t_ff   [3];
   logic signed [ADJ_W-1:0]  s5_adj_ff [3][3];
   logic [DET_W-1:0]         s5_mag_ff;
   logic                     s5_neg_ff;
   logic                     s5_sing_ff;

   assign dround  = s4_dsum_ff + DSUM_W'(1 << (FRAC_BITS - 1));
   assign det     = dround[DSUM_W-1:FRAC_BITS];
   assign mag_in  = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
   // zero determinant is singular even with a zero threshold
   assign sing_in = (mag_in == '0) || (mag_in < DET_W'(thr_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (front_en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         s5_t_ff    <= s4_t_ff;
         s5_adj_ff  <= s4_adj_ff;
         s5_mag_ff  <= mag_in;
         s5_neg_ff  <= det[DET_W-1];
         s5_sing_ff <= sing_in;
      end
   end

   // ------------------------------------------------- row sequencer
   // holds one matrix and issues rows 0..3 on consecutive cycles unless rsp stalls
   logic signed [DW-1:0]    exp_t_ff   [3];
   logic signed [ADJ_W-1:0] exp_adj_ff [3][3];
   logic [DET_W-1:0]        exp_mag_ff;
   logic                    exp_neg_ff;
   logic                    exp_sing_ff;

   logic signed [ADJ_W-1:0] sel_adj [3];
   logic signed [DW-1:0]    sel_t;
   logic [NUM_W-1:0]        div_num [3];
   logic [DEN_W-1:0]        div_den;
   logic                    div_neg [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_valid_ff <= 1'b0;
         exp_row_ff   <= ROW_FIRST;
      end else if (back_en) begin
         if (exp_free) begin
            exp_valid_ff <= s5_valid_ff;
            exp_row_ff   <= ROW_FIRST;
         end else begin
            exp_row_ff <= exp_row_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         exp_t_ff    <= s5_t_ff;
         exp_adj_ff  <= s5_adj_ff;
         exp_mag_ff  <= s5_mag_ff;
         exp_neg_ff  <= s5_neg_ff;
         exp_sing_ff <= s5_sing_ff;
      end
   end

   // translation slot feeds row 0 through the lanes; its quotients are unused
   always_comb begin
      unique case (exp_row_ff)
         2'd1: begin
            sel_adj = exp_adj_ff[1];
            sel_t   = exp_t_ff[1];
         end
         2'd2: begin
            sel_adj = exp_adj_ff[2];
            sel_t   = exp_t_ff[2];
         end
         default: begin
            sel_adj = exp_adj_ff[0];
            sel_t   = exp_t_ff[0];
         end
      endcase
   end

   // (2|adj|*2^f + |det|) / (2|det|) rounds the quotient half away from zero
   assign div_den = DEN_W'(exp_mag_ff) << 1;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         logic [ADJ_W-1:0] a_mag;
         a_mag      = sel_adj[j][ADJ_W-1] ? ADJ_W'(-sel_adj[j]) : ADJ_W'(sel_adj[j]);
         div_num[j] = (NUM_W'(a_mag) << (FRAC_BITS + 1)) + NUM_W'(exp_mag_ff);
         div_neg[j] = sel_adj[j][ADJ_W-1] ^ exp_neg_ff;
      end
   end

   // ------------------------------------------------ divider lanes
   ami_side_type         side_ff [DIV_LAT];
   logic signed [DW-1:0] inv_val  [3];
   logic                 inv_clip [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            side_ff[k] <= '0;
         end
      end else if (back_en) begin
         side_ff[0] <= '{valid: exp_valid_ff, row: exp_row_ff,
                         singular: exp_sing_ff, t: sel_t};
         for (int k = 1; k < DIV_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_lane
      ami_div u_div (
         .clock  (clock),
         .en     (back_en),
         .in_num (div_num[j]),
         .in_den (div_den),
         .in_neg (div_neg[j]),
         .quo    (inv_val[j]),
         .clip   (inv_clip[j])
      );
   end

   // ---------------------------------- product stage: t[row] * inv[row][j]
   logic                     p_valid_ff;
   logic [1:0]               p_row_ff;
   logic                     p_sing_ff;
   logic                     p_clip_ff;
   logic signed [DW-1:0]     p_val_ff  [3];
   logic signed [PROD_W-1:0] p_prod_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (back_en) begin
         p_valid_ff <= side_ff[DIV_LAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         p_row_ff  <= side_ff[DIV_LAT-1].row;
         p_sing_ff <= side_ff[DIV_LAT-1].singular;
         p_clip_ff <= inv_clip[0] || inv_clip[1] || inv_clip[2];
         for (int j = 0; j < 3; j++) begin
            p_val_ff[j]  <= inv_val[j];
            p_prod_ff[j] <= PROD_W'(side_ff[DIV_LAT-1].t) * PROD_W'(inv_val[j]);
         end
      end
   end

   // ------------------------- accumulate stage, translation row rounding
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [TR_W-1:0]  tr_in  [3];
   logic                    a_valid_ff;
   logic [1:0]              a_row_ff;
   logic                    a_sing_ff;
   logic                    a_clip_ff;
   logic signed [TR_W-1:0]  a_val_ff [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         logic signed [ACC_W:0] nr;
         nr       = -(ACC_W+1)'(acc_ff[j]) + (ACC_W+1)'(1 << (FRAC_BITS - 1));
         tr_in[j] = nr[ACC_W:FRAC_BITS];
      end
   end

   // rows 0..2 add into the running column sums, row 3 reads them
   always_ff @(posedge clock) begin
      if (back_en && p_valid_ff && (p_row_ff != ROW_LAST)) begin
         for (int j = 0; j < 3; j++) begin
            acc_ff[j] <= ((p_row_ff == ROW_FIRST) ? ACC_W'(0) : acc_ff[j])
                       + ACC_W'(p_prod_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (back_en) begin
         a_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         a_row_ff  <= p_row_ff;
         a_sing_ff <= p_sing_ff;
         a_clip_ff <= (p_row_ff != ROW_LAST) && p_clip_ff;
         for (int j = 0; j < 3; j++) begin
            a_val_ff[j] <= (p_row_ff == ROW_LAST) ? tr_in[j] : TR_W'(p_val_ff[j]);
         end
      end
   end

   // -------------------------------------------- output register
   logic signed [DW-1:0] o_val  [3];
   logic                 o_clip [3];
   logic signed [DW-1:0] one_hot_val [3];
   ami_rsp_type          rsp_data_ff;
   ami_rsp_type          rsp_in;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         logic hi;
         logic lo;
         hi = !a_val_ff[j][TR_W-1] && (|a_val_ff[j][TR_W-2:DW-1]);
         lo = a_val_ff[j][TR_W-1] && !(&a_val_ff[j][TR_W-2:DW-1]);
         o_clip[j] = hi || lo;
         if (hi) begin
            o_val[j] = {1'b0, {(DW-1){1'b1}}};
         end else if (lo) begin
            o_val[j] = {1'b1, {(DW-1){1'b0}}};
         end else begin
            o_val[j] = a_val_ff[j][DW-1:0];
         end
         // identity row for the singular case
         one_hot_val[j] = (a_row_ff == 2'(j)) ? DW'(1 << FRAC_BITS) : '0;
      end
   end

   always_comb begin
      rsp_in.row_index = a_row_ff;
      rsp_in.singular  = a_sing_ff;
      rsp_in.last      = (a_row_ff == ROW_LAST);
      if (a_sing_ff) begin
         rsp_in.col0      = one_hot_val[0];
         rsp_in.col1      = one_hot_val[1];
         rsp_in.col2      = one_hot_val[2];
         rsp_in.saturated = 1'b0;
      end else begin
         rsp_in.col0      = o_val[0];
         rsp_in.col1      = o_val[1];
         rsp_in.col2      = o_val[2];
         rsp_in.saturated = a_clip_ff || o_clip[0] || o_clip[1] || o_clip[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/ami_check.sv =====
// ============================================================================
// ami_check
// Port-level checks of the affine matrix inverse, bound to the top level.
// ============================================================================
module ami_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input ami_pkg::ami_rsp_type       rsp_data
);
   import ami_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // last marks the translation row only
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.row_index == ROW_LAST)))
      else $error("last flag does not match row index");

   // identity rows never report clipping
   a_sing_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |-> !rsp_data.saturated)
      else $error("singular row flagged saturated");

   // after a row other than the last is taken, the next row follows in order
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=>
         rsp_valid |-> (rsp_data.row_index == $past(rsp_data.row_index) + 2'd1))
      else $error("result rows out of order");

   // nothing is shown right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind affine_matrix_inverse ami_check u_ami_check (.*);

// ===== sim/ami_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ami_checker
// Watches the request, result and register ports of the affine matrix
// inverse, predicts four inverse rows per request and compares them.
// ============================================================================
module ami_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  ami_pkg::ami_req_type         req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  ami_pkg::ami_rsp_type         rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ami_pkg::CSR_AW-1:0]   paddr,
   input  logic [ami_pkg::CSR_DW-1:0]   pwdata,
   input  logic                         pready,
   output int                           mismatch_count,
   output int                           rows_pending
);
   import ami_pkg::*;

   typedef logic signed [127:0] wide_type;

   logic [THR_W-1:0] det_limit;
   ami_rsp_type      inverse_rows_q[$];

   function automatic wide_type fx_round(wide_type v);
      wide_type half;
      half = wide_type'(1) <<< (FRAC_BITS - 1);
      return (v + half) >>> FRAC_BITS;
   endfunction

   function automatic logic [DW-1:0] clip32(wide_type v, inout logic clip);
      wide_type lo, hi;
      lo = -(wide_type'(1) <<< 31);
      hi = (wide_type'(1) <<< 31) - 1;
      if (v < lo) begin
         clip = 1'b1;
         return 32'h8000_0000;
      end
      if (v > hi) begin
         clip = 1'b1;
         return 32'h7FFF_FFFF;
      end
      return v[DW-1:0];
   endfunction

   function automatic wide_type minor(wide_type p, wide_type q, wide_type r, wide_type s);
      return fx_round(p * q - r * s);
   endfunction

   // four rows of the inverse for one request
   function automatic void predict_inverse(ami_req_type m, logic [THR_W-1:0] thr);
      wide_type a[3][3];
      wide_type t[3];
      wide_type adj[3][3];
      wide_type det, mag, num, nm, q, s;
      logic [DW-1:0] rows[4][3];
      logic clip[4];
      logic sing;
      ami_rsp_type r;
      a[0][0] = m.m00; a[0][1] = m.m01; a[0][2] = m.m02;
      a[1][0] = m.m10; a[1][1] = m.m11; a[1][2] = m.m12;
      a[2][0] = m.m20; a[2][1] = m.m21; a[2][2] = m.m22;
      t[0] = m.tx; t[1] = m.ty; t[2] = m.tz;
      adj[0][0] = minor(a[1][1], a[2][2], a[1][2], a[2][1]);
      adj[0][1] = minor(a[0][2], a[2][1], a[0][1], a[2][2]);
      adj[0][2] = minor(a[0][1], a[1][2], a[0][2], a[1][1]);
      adj[1][0] = minor(a[1][2], a[2][0], a[1][0], a[2][2]);
      adj[1][1] = minor(a[0][0], a[2][2], a[0][2], a[2][0]);
      adj[1][2] = minor(a[0][2], a[1][0], a[0][0], a[1][2]);
      adj[2][0] = minor(a[1][0], a[2][1], a[1][1], a[2][0]);
      adj[2][1] = minor(a[0][1], a[2][0], a[0][0], a[2][1]);
      adj[2][2] = minor(a[0][0], a[1][1], a[0][1], a[1][0]);
      det = fx_round(a[0][0] * adj[0][0] + a[0][1] * adj[1][0] + a[0][2] * adj[2][0]);
      mag = (det < 0) ? -det : det;
      sing = (mag == 0) || (mag < wide_type'(thr));
      for (int i = 0; i < 4; i++) clip[i] = 1'b0;
      if (sing) begin
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++)
               rows[i][j] = (i == j) ? (DW'(1) << FRAC_BITS) : '0;
      end else begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               num = adj[i][j] <<< FRAC_BITS;
               nm = (num < 0) ? -num : num;
               // round to nearest, ties away from zero
               q = (2 * nm + mag) / (2 * mag);
               if ((num < 0) != (det < 0)) q = -q;
               rows[i][j] = clip32(q, clip[i]);
            end
         for (int j = 0; j < 3; j++) begin
            s = t[0] * wide_type'($signed(rows[0][j]))
              + t[1] * wide_type'($signed(rows[1][j]))
              + t[2] * wide_type'($signed(rows[2][j]));
            rows[3][j] = clip32(fx_round(-s), clip[3]);
         end
      end
      for (int i = 0; i < 4; i++) begin
         r.row_index = i[1:0];
         r.col0      = rows[i][0];
         r.col1      = rows[i][1];
         r.col2      = rows[i][2];
         r.singular  = sing;
         r.saturated = clip[i];
         r.last      = (i == 3);
         inverse_rows_q.push_back(r);
      end
   endfunction

   assign rows_pending = inverse_rows_q.size();

   always @(posedge clock) begin
      ami_rsp_type want;
      if (reset) begin
         det_limit      <= THR_RESET;
         mismatch_count <= 0;
         inverse_rows_q.delete();
      end else begin
         if (psel && penable && pwrite && pready
             && paddr[CSR_AW-1:2] == REG_DET_THRESHOLD)
            det_limit <= pwdata[THR_W-1:0];
         if (req_valid && req_ready)
            predict_inverse(req_data, det_limit);
         if (rsp_valid && rsp_ready) begin
            if (inverse_rows_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result row %0d", rsp_data.row_index);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = inverse_rows_q.pop_front();
               if (want.row_index !== rsp_data.row_index || want.col0 !== rsp_data.col0
                   || want.col1 !== rsp_data.col1 || want.col2 !== rsp_data.col2
                   || want.singular !== rsp_data.singular
                   || want.saturated !== rsp_data.saturated || want.last !== rsp_data.last)
               begin
                  if (mismatch_count < 10)
                     $display({"row mismatch: exp row=%0d %h %h %h s=%b c=%b l=%b,",
                               " got row=%0d %h %h %h s=%b c=%b l=%b"},
                        want.row_index, want.col0, want.col1, want.col2, want.singular,
                        want.saturated, want.last, rsp_data.row_index, rsp_data.col0,
                        rsp_data.col1, rsp_data.col2, rsp_data.singular,
                        rsp_data.saturated, rsp_data.last);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stimulus and verdict for the affine matrix inverse: directed matrices,
// threshold sweeps and random requests under random back-pressure.
// ============================================================================
module tb_top;
   import ami_pkg::*;

   localparam int STALL_LIMIT = 6000;   // cycles without any handshake
   localparam int DRAIN_WAIT  = 60;     // covers the whole pipe
   localparam logic [CSR_AW-1:0] ADDR_THR    = {REG_DET_THRESHOLD, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_UNUSED = 3'd4;   // no register here
   localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   ami_req_type        req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   ami_rsp_type        rsp_data;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [CSR_AW-1:0]  paddr = '0;
   logic [CSR_DW-1:0]  pwdata = '0;
   logic [CSR_DW-1:0]  prdata;
   logic               pready;

   int  mismatch_count;
   int  rows_pending;
   bit  idling = 1'b1;      // random gaps on both sides
   bit  long_hold = 1'b0;   // asks the receiver for one long stall
   int  quiet_cycles = 0;

   always #6 clock = ~clock;

   affine_matrix_inverse DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   ami_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .mismatch_count, .rows_pending
   );

   // receiver: random stall bursts, plus one long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold  = 1'b0;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog: nothing accepted for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("affine_matrix_inverse verification failed");
         $finish;
      end
   end

   // register write: setup cycle, then access cycle
   task automatic csr_write(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // stop offering, wait for every row to come back, then let the pipe settle
   task automatic drain_rows();
      req_valid <= 1'b0;
      while (rows_pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_threshold(logic [THR_W-1:0] thr);
      drain_rows();
      csr_write(ADDR_THR, CSR_DW'(thr));
      csr_write(ADDR_UNUSED, $urandom());
   endtask

   // offer one request and hold it until taken
   task automatic send_matrix(ami_req_type m);
      int gap;
      if (idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic ami_req_type make_matrix(logic [DW-1:0] d0, logic [DW-1:0] d1,
                                               logic [DW-1:0] d2, logic [DW-1:0] t);
      ami_req_type m;
      m = '0;
      m.m00 = d0; m.m11 = d1; m.m22 = d2;
      m.tx = t; m.ty = -t; m.tz = t;
      return m;
   endfunction

   function automatic logic [DW-1:0] modest();
      return DW'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
   endfunction

   // mostly well-conditioned matrices, some raw noise and degenerate ones
   function automatic ami_req_type random_matrix();
      ami_req_type m;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         m = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      end else begin
         m.m00 = modest(); m.m01 = modest(); m.m02 = modest();
         m.m10 = modest(); m.m11 = modest(); m.m12 = modest();
         m.m20 = modest(); m.m21 = modest(); m.m22 = modest();
         m.tx  = $urandom(); m.ty = modest(); m.tz = modest();
         if (pick < 30) begin
            // dependent rows give a zero determinant
            m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
         end else if (pick < 40) begin
            // tiny elements give a tiny determinant
            m.m00 = m.m00 >>> 8; m.m11 = m.m11 >>> 8; m.m22 = m.m22 >>> 8;
            m.m01 = m.m01 >>> 12; m.m12 = m.m12 >>> 12; m.m20 = m.m20 >>> 12;
         end
      end
      return m;
   endfunction

   task automatic random_matrices(int count);
      for (int i = 0; i < count; i++) send_matrix(random_matrix());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, default threshold
      send_matrix(make_matrix(ONE, ONE, ONE, 32'h0123_4567));
      send_matrix(make_matrix(ONE, ONE, ONE, 32'h7FFF_FFFF));      // full-scale translation
      send_matrix('0);                                             // zero determinant
      send_matrix({12{32'h7FFF_FFFF}});
      send_matrix({12{32'h8000_0000}});
      send_matrix(make_matrix(32'h0004_0000, 32'h0004_0000, 32'h0004_0000, ONE));
      send_matrix(make_matrix(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, ONE));
      send_matrix(make_matrix(-ONE, 2 * ONE, ONE >> 1, 32'h8000_0000));
      send_matrix(make_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, -ONE));
      send_matrix({ONE, ONE, 32'd0, 32'd0, ONE, ONE, ONE, 32'd0, ONE, ONE, ONE, ONE});

      // threshold zero: only an exact zero determinant is singular
      set_threshold('0);
      send_matrix(make_matrix(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, ONE));
      send_matrix(make_matrix(32'h0000_1000, 32'h0000_1000, 32'h0000_1000, ONE));
      send_matrix(make_matrix(32'h0001_0000, 32'h0100_0000, 32'h0100_0000, 32'h7FFF_0000));
      random_matrices(20);

      // threshold 1.0: anything below 1.0 counts as singular
      set_threshold(THR_W'(1) << FRAC_BITS);
      send_matrix(make_matrix(ONE, ONE, ONE, ONE));
      send_matrix(make_matrix(ONE, ONE, ONE - 1, ONE));
      random_matrices(20);

      // random threshold; receiver stalls long while requests keep coming
      set_threshold(THR_W'($urandom_range(0, 1 << 20)));
      random_matrices(10);
      long_hold = 1'b1;
      random_matrices(25);

      // sender pauses until every row is back
      req_valid <= 1'b0;
      while (rows_pending != 0) @(posedge clock);
      random_matrices(10);

      // back to the reset value, final stretch with no idling
      set_threshold(THR_W'(17));
      random_matrices(10);
      idling = 1'b0;
      random_matrices(20);

      drain_rows();
      if (mismatch_count == 0 && rows_pending == 0)
         $display("affine_matrix_inverse verification clean");
      else
         $display("affine_matrix_inverse verification failed");
      $finish;
   end

endmodule
